/* src/srt_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and sizes of the sorted record table insert unit
// depends on nothing

package srt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 24;
    localparam int CAT_W       = 8;
    localparam int PRICE_W     = 24;
    localparam int STOCK_W     = 16;
    localparam int ACTION_W    = 2;
    localparam int RIDX_W      = 6;
    localparam int STATUS_W    = 3;
    localparam int POS_W       = 6;
    localparam int COUNT_OUT_W = 7;
    localparam int GRP_SIZE    = 8;
    localparam int N_GRP       = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CAT_W-1:0]   category;
        logic [PRICE_W-1:0] price_cents;
        logic [STOCK_W-1:0] stock_units;
        logic               imported;
    } t_record;

    typedef struct packed {
        logic cmp_en;
        logic occ;
        logic at_count;
        logic write;
    } t_cell_ctl;

    typedef struct packed {
        logic move;
        logic match;
        logic landed;
    } t_cell_stat;

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } t_state;

endpackage

/* src/srt_cell.sv */
`timescale 1ns / 1ps
// one table slot: holds a record, compares it against the incoming key and
// shifts up from its lower neighbor on insert; uses srt_pkg

module srt_cell (
    input  logic                      i_clk,
    input  srt_pkg::t_cell_ctl        i_ctl,
    input  logic [srt_pkg::KEY_W-1:0] i_key,
    input  srt_pkg::t_record          i_new_rec,
    input  srt_pkg::t_record          i_prev_rec,
    input  logic                      i_move_prev,
    output srt_pkg::t_record          o_rec,
    output srt_pkg::t_cell_stat       o_stat
);

    srt_pkg::t_record r_rec;
    logic             r_gt;
    logic             r_eq;

    always_comb begin
        o_stat.move   = i_ctl.occ & r_gt;
        o_stat.match  = i_ctl.occ & r_eq;
        o_stat.landed = !i_move_prev & ((i_ctl.occ & r_gt) | i_ctl.at_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_gt <= r_rec.key > i_key;
            r_eq <= r_rec.key == i_key;
        end
        if (i_ctl.write) begin
            if (i_move_prev) begin
                r_rec <= i_prev_rec;
            end else if (o_stat.landed) begin
                r_rec <= i_new_rec;
            end
        end
    end

    assign o_rec = r_rec;

endmodule

/* src/sorted_record_table_insert_unit.sv */
`timescale 1ns / 1ps
// top level of the sorted record table: cell chain, item handshake, read tree
// and result register; uses srt_pkg and srt_cell

// Keeps up to 64 records sorted by ascending key in a chain of cells. At
// acceptance each cell compares its key with the item's key and the read
// tree gathers the addressed entry into eight group registers; in the commit
// state, once the output register is free, the duplicate and full checks
// resolve, the cells above the landing point shift up by one in a single
// step, and the result is loaded into the output register. A new item is
// taken only once the previous one has been committed. Status codes: 0
// inserted, 1 duplicate rejected, 2 full rejected, 3 read ok, 4 read index
// at or beyond count or unused action, 5 cleared. Clear only drops the entry
// count.

module sorted_record_table_insert_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [srt_pkg::ACTION_W-1:0]    i_action,
    input  logic [srt_pkg::KEY_W-1:0]       i_key,
    input  logic [srt_pkg::CAT_W-1:0]       i_category,
    input  logic [srt_pkg::PRICE_W-1:0]     i_price_cents,
    input  logic [srt_pkg::STOCK_W-1:0]     i_stock_units,
    input  logic                            i_imported,
    input  logic [srt_pkg::RIDX_W-1:0]      i_read_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [srt_pkg::STATUS_W-1:0]    o_status,
    output logic [srt_pkg::POS_W-1:0]       o_position,
    output logic [srt_pkg::KEY_W-1:0]       o_out_key,
    output logic [srt_pkg::CAT_W-1:0]       o_out_category,
    output logic [srt_pkg::PRICE_W-1:0]     o_out_price_cents,
    output logic [srt_pkg::STOCK_W-1:0]     o_out_stock_units,
    output logic                            o_out_imported,
    output logic [srt_pkg::COUNT_OUT_W-1:0] o_entry_count_out
);

    srt_pkg::t_state                    r_state;
    srt_pkg::t_state                    n_state;
    logic                               r_reject_dup;
    logic [srt_pkg::CNT_W-1:0]          r_count;
    logic [srt_pkg::CNT_W-1:0]          n_count;
    logic [srt_pkg::ACTION_W-1:0]       r_action;
    srt_pkg::t_record                   r_new_rec;
    logic [srt_pkg::RIDX_W-1:0]         r_read_index;
    srt_pkg::t_record                   r_grp [srt_pkg::N_GRP];
    srt_pkg::t_record                   n_grp [srt_pkg::N_GRP];

    logic                               r_out_valid;
    logic [srt_pkg::STATUS_W-1:0]       r_status;
    logic [srt_pkg::STATUS_W-1:0]       n_status;
    logic [srt_pkg::POS_W-1:0]          r_position;
    logic [srt_pkg::POS_W-1:0]          n_position;
    srt_pkg::t_record                   r_out_rec;
    srt_pkg::t_record                   n_out_rec;
    logic [srt_pkg::COUNT_OUT_W-1:0]    r_out_count;

    logic                               accept;
    logic                               out_free;
    logic                               commit_go;
    logic                               dup_hit;
    logic                               full;
    logic                               ins_ok;
    logic                               read_hit;
    logic [srt_pkg::POS_W-1:0]          land_pos;
    srt_pkg::t_record                   read_rec;
    srt_pkg::t_record                   in_rec;

    srt_pkg::t_cell_ctl                 cell_ctl  [srt_pkg::TABLE_DEPTH];
    srt_pkg::t_cell_stat                cell_stat [srt_pkg::TABLE_DEPTH];
    srt_pkg::t_record                   cell_rec  [srt_pkg::TABLE_DEPTH];
    logic [srt_pkg::TABLE_DEPTH-1:0]    match_vec;
    logic [srt_pkg::TABLE_DEPTH-1:0]    landed_vec;

    assign accept    = i_in_valid & o_in_ready;
    assign out_free  = !r_out_valid | i_out_ready;
    assign commit_go = (r_state == srt_pkg::S_COMMIT) & out_free;

    assign in_rec.key         = i_key;
    assign in_rec.category    = i_category;
    assign in_rec.price_cents = i_price_cents;
    assign in_rec.stock_units = i_stock_units;
    assign in_rec.imported    = i_imported;

    // cell chain
    for (genvar c = 0; c < srt_pkg::TABLE_DEPTH; c++) begin : g_cell
        srt_pkg::t_record prev_rec;
        logic             move_prev;

        if (c == 0) begin : g_first
            assign prev_rec  = '0;
            assign move_prev = 1'b0;
        end else begin : g_rest
            assign prev_rec  = cell_rec[c-1];
            assign move_prev = cell_stat[c-1].move;
        end

        assign cell_ctl[c].cmp_en   = accept;
        assign cell_ctl[c].occ      = r_count > srt_pkg::CNT_W'(c);
        assign cell_ctl[c].at_count = r_count == srt_pkg::CNT_W'(c);
        assign cell_ctl[c].write    = commit_go & ins_ok;
        assign match_vec[c]         = cell_stat[c].match;
        assign landed_vec[c]        = cell_stat[c].landed;

        srt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[c]),
            .i_key       (i_key),
            .i_new_rec   (r_new_rec),
            .i_prev_rec  (prev_rec),
            .i_move_prev (move_prev),
            .o_rec       (cell_rec[c]),
            .o_stat      (cell_stat[c])
        );
    end

    // first level of the read tree, taken with the item
    always_comb begin
        int idx;
        idx = 0;
        for (int g = 0; g < srt_pkg::N_GRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < srt_pkg::GRP_SIZE; j++) begin
                idx = g * srt_pkg::GRP_SIZE + j;
                if (idx < srt_pkg::TABLE_DEPTH && 32'(i_read_index) == 32'(idx)) begin
                    n_grp[g] = srt_pkg::t_record'(n_grp[g] | cell_rec[idx]);
                end
            end
        end
    end

    always_comb begin
        read_rec = '0;
        for (int g = 0; g < srt_pkg::N_GRP; g++) begin
            read_rec = srt_pkg::t_record'(read_rec | r_grp[g]);
        end
    end

    always_comb begin
        land_pos = '0;
        for (int c = 0; c < srt_pkg::TABLE_DEPTH; c++) begin
            if (landed_vec[c]) begin
                land_pos = land_pos | srt_pkg::POS_W'(c);
            end
        end
    end

    assign dup_hit  = |match_vec;
    assign full     = r_count >= srt_pkg::CNT_W'(srt_pkg::TABLE_DEPTH);
    assign ins_ok   = (r_action == srt_pkg::ACT_INSERT) & !(r_reject_dup & dup_hit) & !full;
    assign read_hit = 32'(r_read_index) < 32'(r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_status   = srt_pkg::ST_NO_ENTRY;
        n_position = '0;
        n_out_rec  = '0;
        unique case (r_state)
            srt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = srt_pkg::S_COMMIT;
                end
            end
            srt_pkg::S_COMMIT: begin
                if (out_free) begin
                    n_state = srt_pkg::S_IDLE;
                end
                case (r_action)
                    srt_pkg::ACT_INSERT: begin
                        if (r_reject_dup && dup_hit) begin
                            n_status = srt_pkg::ST_DUPLICATE;
                        end else if (full) begin
                            n_status = srt_pkg::ST_FULL;
                        end else begin
                            n_status   = srt_pkg::ST_INSERTED;
                            n_position = land_pos;
                            n_count    = r_count + 1'b1;
                        end
                    end
                    srt_pkg::ACT_READ: begin
                        if (read_hit) begin
                            n_status   = srt_pkg::ST_READ_OK;
                            n_position = srt_pkg::POS_W'(r_read_index);
                            n_out_rec  = read_rec;
                        end
                    end
                    srt_pkg::ACT_CLEAR: begin
                        n_status = srt_pkg::ST_CLEARED;
                        n_count  = '0;
                    end
                    default: begin
                        n_status = srt_pkg::ST_NO_ENTRY;
                    end
                endcase
            end
            default: begin
                n_state = srt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= srt_pkg::S_IDLE;
            r_count      <= '0;
            r_reject_dup <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit_go) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_reject_dup <= i_cfg_wdata;
            end
            if (commit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action     <= i_action;
            r_new_rec    <= in_rec;
            r_read_index <= i_read_index;
            r_grp        <= n_grp;
        end
        if (commit_go) begin
            r_status    <= n_status;
            r_position  <= n_position;
            r_out_rec   <= n_out_rec;
            r_out_count <= srt_pkg::COUNT_OUT_W'(n_count);
        end
    end

    assign o_in_ready        = r_state == srt_pkg::S_IDLE;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_position        = r_position;
    assign o_out_key         = r_out_rec.key;
    assign o_out_category    = r_out_rec.category;
    assign o_out_price_cents = r_out_rec.price_cents;
    assign o_out_stock_units = r_out_rec.stock_units;
    assign o_out_imported    = r_out_rec.imported;
    assign o_entry_count_out = r_out_count;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srt_pkg::CNT_W'(srt_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_landing_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srt_pkg::S_COMMIT && r_action == srt_pkg::ACT_INSERT && !full)
        |-> $onehot(landed_vec))
        else $error("insert landing point not unique");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit_go && ins_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted insert did not grow the table");

    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_go |=> (r_state == srt_pkg::S_IDLE) && o_out_valid)
        else $error("commit did not present a result");

endmodule

/* tb/sorted_record_table_insert_unit_test.sv */
`timescale 1ns / 1ps
// self-checking testbench of the sorted record table insert unit
// drives items with random bursts and stalls and checks each result against a table predictor
// depends on srt_pkg and sorted_record_table_insert_unit

module sorted_record_table_insert_unit_test;
    import srt_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 700;
    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        t_record             rec;
        logic [RIDX_W-1:0]   read_index;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [POS_W-1:0]       position;
        t_record                rec;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_outcome;

    class table_scoreboard;
        t_record  rows [TABLE_DEPTH];
        int       used;
        bit       reject_dup;
        t_outcome awaited_outcomes [$];
        int       errors;

        function new();
            used       = 0;
            reject_dup = 1'b1;
            errors     = 0;
        endfunction

        function int pending();
            return awaited_outcomes.size();
        endfunction

        function void set_dup_check(input bit v);
            reject_dup = v;
        endfunction

        function void note_accepted(input t_item it);
            t_outcome e;
            int       slot;
            bit       dup;
            e = '0;
            e.status = ST_NO_ENTRY;
            case (it.action)
                ACT_INSERT: begin
                    dup = 1'b0;
                    for (int i = 0; i < used; i++) begin
                        if (rows[i].key == it.rec.key) begin
                            dup = 1'b1;
                        end
                    end
                    if (reject_dup && dup) begin
                        e.status = ST_DUPLICATE;
                    end else if (used >= TABLE_DEPTH) begin
                        e.status = ST_FULL;
                    end else begin
                        slot = used;
                        while (slot > 0 && rows[slot-1].key > it.rec.key) begin
                            rows[slot] = rows[slot-1];
                            slot--;
                        end
                        rows[slot] = it.rec;
                        used++;
                        e.status   = ST_INSERTED;
                        e.position = POS_W'(slot);
                    end
                end
                ACT_READ: begin
                    if (int'(it.read_index) < used) begin
                        e.status   = ST_READ_OK;
                        e.position = it.read_index;
                        e.rec      = rows[it.read_index];
                    end
                end
                ACT_CLEAR: begin
                    used     = 0;
                    e.status = ST_CLEARED;
                end
                default: ;
            endcase
            e.entry_count = COUNT_OUT_W'(used);
            awaited_outcomes.push_back(e);
        endfunction

        task report_mismatch(input string field, input int unsigned got,
                             input int unsigned want);
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, field, got,
                     want);
            errors++;
        endtask

        task check_result(input t_outcome got);
            t_outcome want;
            if (awaited_outcomes.size() == 0) begin
                report_mismatch("result with none awaited, status", got.status, 0);
                return;
            end
            want = awaited_outcomes.pop_front();
            if (got.status != want.status)
                report_mismatch("status", got.status, want.status);
            if (got.position != want.position)
                report_mismatch("position", got.position, want.position);
            if (got.rec.key != want.rec.key)
                report_mismatch("key", got.rec.key, want.rec.key);
            if (got.rec.category != want.rec.category)
                report_mismatch("category", got.rec.category, want.rec.category);
            if (got.rec.price_cents != want.rec.price_cents)
                report_mismatch("price_cents", got.rec.price_cents, want.rec.price_cents);
            if (got.rec.stock_units != want.rec.stock_units)
                report_mismatch("stock_units", got.rec.stock_units, want.rec.stock_units);
            if (got.rec.imported != want.rec.imported)
                report_mismatch("imported", got.rec.imported, want.rec.imported);
            if (got.entry_count != want.entry_count)
                report_mismatch("entry_count", got.entry_count, want.entry_count);
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_wdata;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [ACTION_W-1:0]    i_action;
    logic [KEY_W-1:0]       i_key;
    logic [CAT_W-1:0]       i_category;
    logic [PRICE_W-1:0]     i_price_cents;
    logic [STOCK_W-1:0]     i_stock_units;
    logic                   i_imported;
    logic [RIDX_W-1:0]      i_read_index;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [STATUS_W-1:0]    o_status;
    logic [POS_W-1:0]       o_position;
    logic [KEY_W-1:0]       o_out_key;
    logic [CAT_W-1:0]       o_out_category;
    logic [PRICE_W-1:0]     o_out_price_cents;
    logic [STOCK_W-1:0]     o_out_stock_units;
    logic                   o_out_imported;
    logic [COUNT_OUT_W-1:0] o_entry_count_out;

    table_scoreboard sb;
    int items_sent;
    int burst_left;
    int idle_cycles;
    bit hold_req;

    sorted_record_table_insert_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_action          (i_action),
        .i_key             (i_key),
        .i_category        (i_category),
        .i_price_cents     (i_price_cents),
        .i_stock_units     (i_stock_units),
        .i_imported        (i_imported),
        .i_read_index      (i_read_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_position        (o_position),
        .o_out_key         (o_out_key),
        .o_out_category    (o_out_category),
        .o_out_price_cents (o_out_price_cents),
        .o_out_stock_units (o_out_stock_units),
        .o_out_imported    (o_out_imported),
        .o_entry_count_out (o_entry_count_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // fill: 0 all zeros, 1 all ones, otherwise random record fields; the key always comes from the argument
    function automatic t_item make_item(input logic [ACTION_W-1:0] action,
                                        input logic [KEY_W-1:0] key,
                                        input logic [RIDX_W-1:0] ridx, input int fill);
        t_item it;
        it.action     = action;
        it.read_index = ridx;
        if (fill == 0) begin
            it.rec = '0;
        end else if (fill == 1) begin
            it.rec = '1;
        end else begin
            it.rec.category    = CAT_W'($urandom);
            it.rec.price_cents = PRICE_W'($urandom);
            it.rec.stock_units = STOCK_W'($urandom);
            it.rec.imported    = 1'($urandom);
        end
        it.rec.key = key;
        return it;
    endfunction

    function automatic t_item random_item(input int unsigned key_span);
        t_item       it;
        int unsigned roll;
        logic [KEY_W-1:0] key;
        logic [RIDX_W-1:0] ridx;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            key = '0;
        else if (roll < 6)
            key = '1;
        else
            key = KEY_W'($urandom_range(0, key_span));
        if ($urandom_range(0, 9) < 7)
            ridx = RIDX_W'($urandom_range(0, (sb.used < TABLE_DEPTH) ? sb.used : TABLE_DEPTH - 1));
        else
            ridx = RIDX_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 60)
            it = make_item(ACT_INSERT, key, ridx, 2);
        else if (roll < 88)
            it = make_item(ACT_READ, key, ridx, 2);
        else if (roll < 94)
            it = make_item(ACT_CLEAR, key, ridx, 2);
        else
            it = make_item(ACT_UNUSED, key, ridx, 2);
        return it;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic offer(input t_item it);
        i_in_valid    <= 1'b1;
        i_action      <= it.action;
        i_key         <= it.rec.key;
        i_category    <= it.rec.category;
        i_price_cents <= it.rec.price_cents;
        i_stock_units <= it.rec.stock_units;
        i_imported    <= it.rec.imported;
        i_read_index  <= it.read_index;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_accepted(it);
        items_sent++;
        pace();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_dup_check(input bit v);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_dup_check(v);
    endtask

    task automatic fill_until_full(input int unsigned key_span);
        offer(make_item(ACT_CLEAR, '0, '0, 2));
        while (sb.used < TABLE_DEPTH) begin
            if ($urandom_range(0, 4) == 0)
                offer(make_item(ACT_READ, '0, RIDX_W'($urandom), 2));
            else
                offer(make_item(ACT_INSERT, KEY_W'($urandom_range(0, key_span)), '0, 2));
        end
        // existing key on a full table, then a fresh one
        offer(make_item(ACT_INSERT, sb.rows[$urandom_range(0, TABLE_DEPTH - 1)].key, '0, 2));
        offer(make_item(ACT_INSERT, KEY_W'($urandom), '0, 2));
        offer(make_item(ACT_READ, '0, RIDX_W'(TABLE_DEPTH - 1), 2));
        offer(make_item(ACT_READ, '0, '0, 2));
    endtask

    // result side: checks accepted results and stalls on its own pattern
    initial begin
        t_outcome    got;
        int          hold_left;
        int          phase_cnt;
        logic [15:0] pattern;
        bit          hold_done;
        hold_left = 0;
        phase_cnt = 0;
        pattern   = '1;
        hold_done = 1'b0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (o_out_valid && i_out_ready) begin
                got.status          = o_status;
                got.position        = o_position;
                got.rec.key         = o_out_key;
                got.rec.category    = o_out_category;
                got.rec.price_cents = o_out_price_cents;
                got.rec.stock_units = o_out_stock_units;
                got.rec.imported    = o_out_imported;
                got.entry_count     = o_entry_count_out;
                sb.check_result(got);
            end
            if (hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (phase_cnt == 0) begin
                phase_cnt = $urandom_range(16, 80);
                pattern   = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            end
            phase_cnt--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= pattern[phase_cnt % 16];
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          round;
        int unsigned span;
        sb          = new();
        items_sent  = 0;
        burst_left  = 1;
        hold_req    = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_INSERT;
        i_key         <= '0;
        i_category    <= '0;
        i_price_cents <= '0;
        i_stock_units <= '0;
        i_imported    <= 1'b0;
        i_read_index  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, duplicate checking at its reset value
        offer(make_item(ACT_READ, '0, '0, 0));
        offer(make_item(ACT_INSERT, 24'd500, '0, 0));
        offer(make_item(ACT_INSERT, '1, '1, 1));
        offer(make_item(ACT_INSERT, '0, '0, 2));
        offer(make_item(ACT_INSERT, 24'd500, '0, 2));
        offer(make_item(ACT_INSERT, 24'd250, '0, 2));
        for (int i = 0; i < 4; i++)
            offer(make_item(ACT_READ, '0, RIDX_W'(i), 2));
        offer(make_item(ACT_READ, '0, '1, 2));
        offer(make_item(ACT_READ, '0, RIDX_W'(4), 2));
        offer(make_item(ACT_UNUSED, '1, '0, 1));
        offer(make_item(ACT_CLEAR, '0, '0, 2));
        offer(make_item(ACT_READ, '0, '0, 2));
        offer(make_item(ACT_INSERT, 24'd7, '0, 2));

        // equal keys allowed: each lands after the ones already there
        write_dup_check(1'b0);
        offer(make_item(ACT_INSERT, 24'd7, '0, 2));
        offer(make_item(ACT_INSERT, 24'd7, '0, 1));
        offer(make_item(ACT_INSERT, 24'd3, '0, 2));
        for (int i = 0; i < 5; i++)
            offer(make_item(ACT_READ, '0, RIDX_W'(i), 2));

        write_dup_check(1'b1);
        fill_until_full(24'hFFFFFF);
        write_dup_check(1'b0);
        fill_until_full(31);
        write_dup_check(1'b1);

        round = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 2))
                0:       span = 15;
                1:       span = 255;
                default: span = 24'hFFFFFF;
            endcase
            if (round == 1)
                hold_req = 1'b1;
            repeat ($urandom_range(40, 80)) offer(random_item(span));
            if (round == 3)
                drain();
            if ($urandom_range(0, 2) == 0)
                write_dup_check(!sb.reject_dup);
            round++;
        end

        drain();
        repeat (SETTLE + 4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/srt_pkg.sv
src/srt_cell.sv
src/sorted_record_table_insert_unit.sv
tb/sorted_record_table_insert_unit_test.sv
